// ----- src/assert_macros.svh -----
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CSA_ASSERT(label, prop, msg)
`define CSA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- src/csa_pkg.sv -----
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types and constants of the contiguous slot allocator.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int unsigned Slots = 64;
  localparam int unsigned IdxW  = $clog2(Slots);
  localparam int unsigned CntW  = $clog2(Slots + 1);

  typedef enum logic [2:0] {
    CMD_FIND     = 3'd0,
    CMD_ALLOC    = 3'd1,
    CMD_RELEASE  = 3'd2,
    CMD_EVAL     = 3'd3,
    CMD_REFRESH  = 3'd4,
    CMD_COUNT    = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_WORKING = 2'd1,
    KIND_BACKUP  = 2'd2
  } kind_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // capture the item and clear accumulators
    logic step;   // process the slot under the scan pointer
    logic emit;   // drive the single result of a non-find command
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;  // pointer is on the final slot
    logic bad;        // range check failed or unknown command
    logic is_find;
  } stat_t;

endpackage

// ----- src/csa_datapath.sv -----
// ----------------------------------------------------------------------------
// csa_datapath
// Slot map, scan pointer, run and fragment counters, and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module csa_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [2:0]                command_i,
  input  logic                      path_is_backup_i,
  input  logic [5:0]                start_slot_i,
  input  logic [6:0]                demand_i,
  input  csa_pkg::ctrl_t            ctrl_i,
  output csa_pkg::stat_t            stat_o,
  output logic                      valid_o,
  output logic [5:0]                slot_index_o,
  output logic                      found_o,
  output logic                      last_o,
  output logic signed [7:0]         frag_delta_o,
  output logic [6:0]                unused_count_o,
  output logic [6:0]                new_slots_o,
  output logic                      status_o
);
  import csa_pkg::*;

  logic [Slots-1:0] used_q;
  logic [Slots-1:0] share_q;
  logic [7:0]       frags_q;

  // Holder counts and kinds live in a memory. An entry that was never written
  // reads as zero through its touched bit, and the count of the slot under the
  // pointer is registered by the load or the step before the one that uses it.
  logic [1:0]       kind_q   [Slots];
  logic [7:0]       hold_q   [Slots];
  logic [Slots-1:0] touched_q;
  logic [7:0]       hold_rd_q;

  logic [2:0]       cmd_q;
  logic             bk_q;
  logic [5:0]       start_q;
  logic [6:0]       dem_q;
  logic [IdxW-1:0]  ptr_q;
  logic [6:0]       run_q;
  logic [7:0]       cnt_q;     // fragment count being built
  logic [6:0]       free_q;
  logic [6:0]       news_q;
  logic             gap_q;

  logic [7:0] endp;
  logic       in_rng, inr, slot_u, eff_u, last_slot;
  logic [6:0] run_n;
  logic [7:0] cnt_n;
  logic [6:0] free_n;

  logic [IdxW-1:0] rd_addr;
  logic            touch, rel_free, kind_we;
  logic [7:0]      hold_cur, hold_wd;
  kind_e           kind_wd;

  assign endp      = {2'b0, start_q} + {1'b0, dem_q};
  assign in_rng    = endp <= 8'(Slots);
  assign inr       = ({1'b0, ptr_q} >= {1'b0, start_q}) && ({2'b0, ptr_q} < endp);
  assign slot_u    = used_q[ptr_q];
  assign eff_u     = slot_u || ((cmd_q == CMD_EVAL) && inr);
  assign last_slot = ptr_q == IdxW'(Slots - 1);
  assign run_n     = slot_u ? 7'd0 : run_q + 7'd1;
  assign cnt_n     = cnt_q + ((eff_u && gap_q) ? 8'd1 : 8'd0);
  assign free_n    = free_q + (eff_u ? 7'd0 : 7'd1);

  assign stat_o.scan_done = last_slot;
  assign stat_o.is_find   = cmd_q == CMD_FIND;
  assign stat_o.bad       = (cmd_q > CMD_COUNT) ||
                            ((cmd_q != CMD_FIND) && (cmd_q != CMD_REFRESH) && !in_rng);

  assign rd_addr  = ctrl_i.load ? '0 : ptr_q + IdxW'(1);
  assign touch    = ctrl_i.step && !stat_o.bad && inr &&
                    ((cmd_q == CMD_ALLOC) || (cmd_q == CMD_RELEASE));
  assign hold_cur = touched_q[ptr_q] ? hold_rd_q : 8'd0;
  assign rel_free = !bk_q || (hold_cur <= 8'd1);
  assign kind_we  = (cmd_q == CMD_ALLOC) || rel_free;
  assign kind_wd  = (cmd_q == CMD_ALLOC) ? (bk_q ? KIND_BACKUP : KIND_WORKING) : KIND_NONE;

  always_comb begin
    if (cmd_q == CMD_ALLOC) begin
      hold_wd = (hold_cur != 8'hFF) ? hold_cur + 8'd1 : hold_cur;
    end else begin
      hold_wd = (hold_cur != 8'd0) ? hold_cur - 8'd1 : hold_cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (touch) hold_q[ptr_q] <= hold_wd;
    if (touch && kind_we) kind_q[ptr_q] <= kind_wd;
    if (ctrl_i.load || ctrl_i.step) hold_rd_q <= hold_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      share_q   <= '0;
      touched_q <= '0;
      frags_q   <= 8'd1;
      valid_o   <= 1'b0;
      ptr_q     <= '0;
    end else begin
      valid_o <= 1'b0;
      if (ctrl_i.load) begin
        cmd_q   <= command_i;
        bk_q    <= path_is_backup_i;
        start_q <= start_slot_i;
        dem_q   <= demand_i;
        ptr_q   <= '0;
        run_q   <= '0;
        cnt_q   <= 8'd1;
        free_q  <= '0;
        news_q  <= '0;
        gap_q   <= 1'b0;
      end
      if (ctrl_i.step) begin
        ptr_q <= ptr_q + 1'b1;
        run_q <= run_n;
        cnt_q <= cnt_n;
        free_q <= free_n;
        gap_q <= !eff_u;
        if (touch) touched_q[ptr_q] <= 1'b1;
        if (!stat_o.bad && inr) begin
          unique case (cmd_q)
            CMD_ALLOC: begin
              used_q[ptr_q]  <= 1'b1;
              share_q[ptr_q] <= bk_q;
            end
            CMD_RELEASE: begin
              if (rel_free) begin
                used_q[ptr_q] <= 1'b0;
                if (bk_q) share_q[ptr_q] <= 1'b0;
              end
            end
            CMD_COUNT: if (!slot_u) news_q <= news_q + 7'd1;
            default: ;
          endcase
        end
        if (cmd_q == CMD_REFRESH && last_slot) frags_q <= cnt_n;
        // Find emits a result per window end; the last result is flagged later.
        if (cmd_q == CMD_FIND && dem_q != 7'd0 && dem_q <= 7'(Slots)) begin
          if (run_n >= dem_q) begin
            valid_o        <= 1'b1;
            slot_index_o   <= 6'(7'(ptr_q) + 7'd1 - dem_q);
            found_o        <= 1'b1;
            last_o         <= 1'b0;
            frag_delta_o   <= '0;
            unused_count_o <= '0;
            new_slots_o    <= '0;
            status_o       <= 1'b0;
          end
        end
      end
      if (ctrl_i.emit) begin
        valid_o        <= 1'b1;
        slot_index_o   <= '0;
        found_o        <= 1'b0;
        last_o         <= 1'b1;
        frag_delta_o   <= '0;
        unused_count_o <= '0;
        new_slots_o    <= '0;
        status_o       <= stat_o.bad;
        if (!stat_o.bad) begin
          if (cmd_q == CMD_EVAL) begin
            frag_delta_o   <= cnt_q - frags_q;
            unused_count_o <= free_q;
          end
          if (cmd_q == CMD_COUNT) new_slots_o <= bk_q ? news_q : dem_q;
        end
      end
    end
  end

  // The top level holds each find result until the next one is known, so
  // that the final window can carry the last flag.
  `CSA_ASSERT_NEXT(a_emit_last, ctrl_i.emit, valid_o && last_o, "emit without last result")
  `CSA_ASSERT(a_ptr_load, ctrl_i.load |=> ptr_q == '0, "scan pointer not cleared")
  `CSA_ASSERT(a_no_overlap, !(ctrl_i.load && ctrl_i.step), "load during scan")
endmodule

// ----- src/csa_controller.sv -----
// ----------------------------------------------------------------------------
// csa_controller
// Sequencer: accept, scan every slot, then emit a non-find command's result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module csa_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  csa_pkg::stat_t stat_i,
  output csa_pkg::ctrl_t ctrl_o,
  output logic           busy_o
);
  import csa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    ctrl_o.load = (state_q == ST_IDLE) && start_i;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_SCAN;
      ST_SCAN: begin
        ctrl_o.step = 1'b1;
        if (stat_i.scan_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        ctrl_o.emit = !stat_i.is_find;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = state_q != ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `CSA_ASSERT(a_onehot, $onehot(state_q), "state not one-hot")
  `CSA_ASSERT_NEXT(a_start, start_i && !busy_o, busy_o, "start not taken")
  `CSA_ASSERT(a_step_busy, ctrl_o.step |-> busy_o, "step while idle")
endmodule

// ----- src/contiguous_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// contiguous_slot_allocator
// First-fit allocator over a map of contiguous spectrum slots.
// ----------------------------------------------------------------------------
// Usage: drive the command fields and raise start while busy is low; the
// item is taken at that edge and busy stays high until the item is done.
// Every item walks the slot map one slot per cycle with the single scan
// pointer; the block takes no new item until busy is low again.
// Find gives one result per free window while it scans, in rising order, the
// final one carrying last_o; when there is no window it gives one result
// with found_o low. Every other command gives one result after the scan.
// An item's closing result is shown in the first cycle after busy falls.
// Each result is shown for one cycle with valid_o high and must be taken
// then; the receiver cannot stall the block. Reset clears the map to free,
// the stored fragment count to one, and returns the block to idle at once.
// ----------------------------------------------------------------------------
module contiguous_slot_allocator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        command_i,
  input  logic              path_is_backup_i,
  input  logic [5:0]        start_slot_i,
  input  logic [6:0]        demand_i,
  output logic              valid_o,
  output logic [5:0]        slot_index_o,
  output logic              found_o,
  output logic              last_o,
  output logic signed [7:0] frag_delta_o,
  output logic [6:0]        unused_count_o,
  output logic [6:0]        new_slots_o,
  output logic              status_o
);
  import csa_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  dv;
  logic [5:0] d_idx;
  logic d_found, d_last, d_status;
  logic signed [7:0] d_delta;
  logic [6:0] d_unused, d_news;

  // Held find result: released when the next window appears or the scan ends.
  logic       hv_q, any_q;
  logic [5:0] hidx_q;
  logic       fin;

  csa_controller u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .stat_i(stat), .ctrl_o(ctrl), .busy_o(busy)
  );

  csa_datapath u_dp (
    .clk_i, .rst_ni, .command_i, .path_is_backup_i, .start_slot_i, .demand_i,
    .ctrl_i(ctrl), .stat_o(stat), .valid_o(dv), .slot_index_o(d_idx),
    .found_o(d_found), .last_o(d_last), .frag_delta_o(d_delta),
    .unused_count_o(d_unused), .new_slots_o(d_news), .status_o(d_status)
  );

  // Find ends once the last scan step has passed through last_step_q and
  // fin_q and the result of the final slot is in the holding register.
  logic last_step_q, fin_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_step_q <= 1'b0;
      fin_q       <= 1'b0;
    end else begin
      last_step_q <= ctrl.step && stat.scan_done && stat.is_find;
      fin_q       <= last_step_q;
    end
  end
  assign fin = fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q  <= 1'b0;
      any_q <= 1'b0;
    end else begin
      if (ctrl.load) any_q <= 1'b0;
      if (dv && d_found) begin
        hv_q   <= 1'b1;
        hidx_q <= d_idx;
        any_q  <= 1'b1;
      end else if (fin) begin
        hv_q <= 1'b0;
      end
    end
  end

  always_comb begin
    valid_o        = 1'b0;
    slot_index_o   = '0;
    found_o        = 1'b0;
    last_o         = 1'b0;
    frag_delta_o   = '0;
    unused_count_o = '0;
    new_slots_o    = '0;
    status_o       = 1'b0;
    if (dv && !d_found) begin
      valid_o = 1'b1; last_o = d_last; frag_delta_o = d_delta;
      unused_count_o = d_unused; new_slots_o = d_news; status_o = d_status;
    end else if (hv_q && ((dv && d_found) || fin)) begin
      valid_o = 1'b1; slot_index_o = hidx_q; found_o = 1'b1; last_o = fin && !dv;
    end else if (fin && !any_q) begin
      valid_o = 1'b1; last_o = 1'b1;
    end
  end
endmodule
